// File: hw/rtl/fcf_pkg.sv
// shared constants and types for the transmitter coverage fitness block
package fcf_pkg;

    localparam int POS_W            = 9;
    localparam int COVERED_W        = 17;
    localparam int USED_OUT_W       = 10;
    localparam int FIT_W            = 30;
    localparam int FRAC_W           = 16;
    localparam int PCT_SCALE        = 100;
    localparam int PCT_W            = 7;

    localparam int GRID_SIDE_DEF    = 287;
    localparam int COVER_RADIUS_DEF = 20;
    localparam int MAX_TX_DEF       = 512;

    typedef struct packed {
        logic paint_go;
        logic clear_go;
    } map_ctl_t;

endpackage

// File: hw/rtl/transmitter_coverage_fitness.sv
// top level: transmitter coverage fitness evaluator
// a selected word is painted map row by map row through the row memory's
// read-modify-write port; an unselected word that is not last leaves the input open
// a last word adds the S_MUL1 step and, unless no transmitter was used or the
// solution is invalid, the S_MUL2 step and the bit-serial divider, then a clearing pass,
// row by row; after reset the same clearing pass runs before the first word is taken
module transmitter_coverage_fitness
    import fcf_pkg::*;
#(
    parameter int GRID_SIDE        = GRID_SIDE_DEF,
    parameter int COVER_RADIUS     = COVER_RADIUS_DEF,
    parameter int MAX_TRANSMITTERS = MAX_TX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [POS_W-1:0]      pos_x,
    input  logic [POS_W-1:0]      pos_y,
    input  logic                  selected,
    input  logic                  invalid_mark,
    input  logic                  last_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COVERED_W-1:0]  covered_cells,
    output logic [USED_OUT_W-1:0] used_count,
    output logic [FIT_W-1:0]      fitness_q16,
    output logic                  none_used,
    output logic                  was_invalid
);

    localparam int CELL_W = $clog2(GRID_SIDE * GRID_SIDE + 1);
    localparam int USED_W = $clog2(MAX_TRANSMITTERS + 1);
    localparam int A_W    = CELL_W + PCT_W;
    localparam int SQ_W   = 2 * A_W;
    localparam int NUM_W  = SQ_W + FRAC_W;
    localparam int CSQ_W  = 2 * CELL_W;
    localparam int DEN_W  = CSQ_W + USED_W;

    localparam longint CELLS_L = longint'(GRID_SIDE) * longint'(GRID_SIDE);
    localparam logic [CSQ_W-1:0] CELL_SQ = CSQ_W'(CELLS_L * CELLS_L);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAINT = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;

    logic [2:0]            st_reg, st_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic                  inv_reg, inv_next;
    logic                  last_reg, last_next;
    logic [POS_W-1:0]      px_reg, px_next;
    logic [POS_W-1:0]      py_reg, py_next;
    map_ctl_t              ctl_reg, ctl_next;
    logic                  div_go_reg, div_go_next;
    logic [A_W-1:0]        a_reg, a_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic [FIT_W-1:0]      fit_reg, fit_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COVERED_W-1:0]  cov_out_reg, cov_out_next;
    logic [USED_OUT_W-1:0] used_out_reg, used_out_next;
    logic [FIT_W-1:0]      fit_out_reg, fit_out_next;
    logic                  none_out_reg, none_out_next;
    logic                  inv_out_reg, inv_out_next;

    logic                  accept;
    logic                  map_busy;
    logic [CELL_W-1:0]     covered;
    logic                  div_busy;
    logic [FIT_W-1:0]      quo;

    fcf_map #(
        .GRID_SIDE    (GRID_SIDE),
        .COVER_RADIUS (COVER_RADIUS)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_reg),
        .pos_x   (px_reg),
        .pos_y   (py_reg),
        .busy    (map_busy),
        .covered (covered)
    );

    fcf_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (FIT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go_reg),
        .num   ({sq_reg, FRAC_W'(0)}),
        .den   (den_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    assign in_ready = (st_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        st_next        = st_reg;
        used_next      = used_reg;
        inv_next       = inv_reg;
        last_next      = last_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ctl_next       = '0;
        div_go_next    = 1'b0;
        a_next         = a_reg;
        den_next       = den_reg;
        sq_next        = sq_reg;
        fit_next       = fit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cov_out_next   = cov_out_reg;
        used_out_next  = used_out_reg;
        fit_out_next   = fit_out_reg;
        none_out_next  = none_out_reg;
        inv_out_next   = inv_out_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = last_item;
                    if (invalid_mark)
                    begin
                        inv_next = 1'b1;
                    end
                    if (selected)
                    begin
                        if (used_reg != USED_W'(MAX_TRANSMITTERS))
                        begin
                            used_next = used_reg + USED_W'(1);
                        end
                        px_next           = pos_x;
                        py_next           = pos_y;
                        ctl_next.paint_go = 1'b1;
                        st_next           = S_PAINT;
                    end
                    else if (last_item)
                    begin
                        st_next = S_MUL1;
                    end
                end
            end
            S_PAINT:
            begin
                if (!map_busy)
                begin
                    st_next = last_reg ? S_MUL1 : S_IDLE;
                end
            end
            S_MUL1:
            begin
                a_next   = A_W'(covered) * A_W'(PCT_SCALE);
                den_next = DEN_W'(CELL_SQ) * DEN_W'(used_reg);
                if ((used_reg == '0) || inv_reg)
                begin
                    fit_next = '0;
                    st_next  = S_OUT;
                end
                else
                begin
                    st_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                sq_next     = SQ_W'(a_reg) * SQ_W'(a_reg);
                div_go_next = 1'b1;
                st_next     = S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    fit_next = quo;
                    st_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    cov_out_next      = COVERED_W'(covered);
                    used_out_next     = USED_OUT_W'(used_reg);
                    fit_out_next      = fit_reg;
                    none_out_next     = (used_reg == '0);
                    inv_out_next      = inv_reg;
                    used_next         = '0;
                    inv_next          = 1'b0;
                    ctl_next.clear_go = 1'b1;
                    st_next           = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                if (!map_busy)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_CLEAR;
            used_reg      <= '0;
            inv_reg       <= 1'b0;
            last_reg      <= 1'b0;
            ctl_reg       <= '0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            used_reg      <= used_next;
            inv_reg       <= inv_next;
            last_reg      <= last_next;
            ctl_reg       <= ctl_next;
            div_go_reg    <= div_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        a_reg        <= a_next;
        den_reg      <= den_next;
        sq_reg       <= sq_next;
        fit_reg      <= fit_next;
        cov_out_reg  <= cov_out_next;
        used_out_reg <= used_out_next;
        fit_out_reg  <= fit_out_next;
        none_out_reg <= none_out_next;
        inv_out_reg  <= inv_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign covered_cells = cov_out_reg;
    assign used_count    = used_out_reg;
    assign fitness_q16   = fit_out_reg;
    assign none_used     = none_out_reg;
    assign was_invalid   = inv_out_reg;

endmodule

// File: hw/rtl/fcf_map.sv
// coverage map: row memory with read-modify-write painting, new-cell count and clearing pass
module fcf_map
    import fcf_pkg::*;
#(
    parameter int GRID_SIDE    = GRID_SIDE_DEF,
    parameter int COVER_RADIUS = COVER_RADIUS_DEF,
    localparam int CELL_W      = $clog2(GRID_SIDE * GRID_SIDE + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  map_ctl_t          ctl,
    input  logic [POS_W-1:0]  pos_x,
    input  logic [POS_W-1:0]  pos_y,
    output logic              busy,
    output logic [CELL_W-1:0] covered
);

    localparam int ROW_W = $clog2(GRID_SIDE);
    localparam int WIN_W = (2 * COVER_RADIUS + 1 < GRID_SIDE) ? 2 * COVER_RADIUS + 1 : GRID_SIDE;
    localparam int CNT_W = $clog2(WIN_W + 1);
    localparam int CW    = $clog2(2 ** POS_W + COVER_RADIUS + GRID_SIDE);

    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_SETUP = 3'd1;
    localparam logic [2:0] M_RUN   = 3'd2;
    localparam logic [2:0] M_DRAIN = 3'd3;
    localparam logic [2:0] M_CLEAR = 3'd4;

    function automatic logic [CNT_W-1:0] popcnt(input logic [WIN_W-1:0] v);
        logic [CNT_W-1:0] s;
        s = '0;
        for (int i = 0; i < WIN_W; i++)
        begin
            s = s + CNT_W'(v[i]);
        end
        return s;
    endfunction

    logic [GRID_SIDE-1:0] mem [GRID_SIDE];

    logic [2:0]           mst_reg, mst_next;
    logic [POS_W-1:0]     px_reg, px_next;
    logic [POS_W-1:0]     py_reg, py_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [ROW_W-1:0]     row_end_reg, row_end_next;
    logic [ROW_W-1:0]     y0_reg, y0_next;
    logic [GRID_SIDE-1:0] mask_reg, mask_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [ROW_W-1:0]     rd_addr_reg;
    logic [GRID_SIDE-1:0] rd_data_reg;
    logic                 win_vld_reg, win_vld_next;
    logic [WIN_W-1:0]     win_reg, win_next;
    logic [CELL_W-1:0]    covered_reg, covered_next;

    logic [CW-1:0]        cx, cy, xe, ye, x0_c, x1_c, y0_c, y1_c;
    logic                 empty;
    logic [GRID_SIDE-1:0] fresh, shifted;
    logic                 we;
    logic [ROW_W-1:0]     waddr;
    logic [GRID_SIDE-1:0] wdata;

    // clipped square bounds
    always_comb
    begin
        cx    = CW'(px_reg);
        cy    = CW'(py_reg);
        xe    = cx + CW'(COVER_RADIUS);
        ye    = cy + CW'(COVER_RADIUS);
        x0_c  = (cx < CW'(COVER_RADIUS)) ? '0 : cx - CW'(COVER_RADIUS);
        y0_c  = (cy < CW'(COVER_RADIUS)) ? '0 : cy - CW'(COVER_RADIUS);
        x1_c  = (xe > CW'(GRID_SIDE - 1)) ? CW'(GRID_SIDE - 1) : xe;
        y1_c  = (ye > CW'(GRID_SIDE - 1)) ? CW'(GRID_SIDE - 1) : ye;
        empty = (x0_c > x1_c) || (y0_c > y1_c);
    end

    always_comb
    begin
        fresh    = mask_reg & ~rd_data_reg;
        shifted  = fresh >> y0_reg;
        win_next = shifted[WIN_W-1:0];
    end

    always_comb
    begin
        mst_next     = mst_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        row_next     = row_reg;
        row_end_next = row_end_reg;
        y0_next      = y0_reg;
        mask_next    = mask_reg;
        rd_vld_next  = 1'b0;
        win_vld_next = rd_vld_reg;
        covered_next = covered_reg + (win_vld_reg ? CELL_W'(popcnt(win_reg)) : '0);
        we           = rd_vld_reg;
        waddr        = rd_addr_reg;
        wdata        = rd_data_reg | mask_reg;
        case (mst_reg)
            M_IDLE:
            begin
                if (ctl.clear_go)
                begin
                    mst_next     = M_CLEAR;
                    row_next     = '0;
                    covered_next = '0;
                end
                else if (ctl.paint_go)
                begin
                    mst_next = M_SETUP;
                    px_next  = pos_x;
                    py_next  = pos_y;
                end
            end
            M_SETUP:
            begin
                for (int i = 0; i < GRID_SIDE; i++)
                begin
                    mask_next[i] = (CW'(i) >= y0_c) && (CW'(i) <= y1_c);
                end
                y0_next      = y0_c[ROW_W-1:0];
                row_next     = x0_c[ROW_W-1:0];
                row_end_next = x1_c[ROW_W-1:0];
                mst_next     = empty ? M_IDLE : M_RUN;
            end
            M_RUN:
            begin
                rd_vld_next = 1'b1;
                if (row_reg == row_end_reg)
                begin
                    mst_next = M_DRAIN;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            M_DRAIN:
            begin
                if (!rd_vld_reg && !win_vld_reg)
                begin
                    mst_next = M_IDLE;
                end
            end
            M_CLEAR:
            begin
                we    = 1'b1;
                waddr = row_reg;
                wdata = '0;
                if (row_reg == ROW_W'(GRID_SIDE - 1))
                begin
                    mst_next = M_IDLE;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            default:
            begin
                mst_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mst_reg     <= M_CLEAR;
            row_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            win_vld_reg <= 1'b0;
            covered_reg <= '0;
        end
        else
        begin
            mst_reg     <= mst_next;
            row_reg     <= row_next;
            rd_vld_reg  <= rd_vld_next;
            win_vld_reg <= win_vld_next;
            covered_reg <= covered_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        row_end_reg <= row_end_next;
        y0_reg      <= y0_next;
        mask_reg    <= mask_next;
        win_reg     <= win_next;
    end

    // row memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (mst_reg == M_RUN)
        begin
            rd_data_reg <= mem[row_reg];
            rd_addr_reg <= row_reg;
        end
    end

    assign busy    = (mst_reg != M_IDLE) || ctl.paint_go || ctl.clear_go;
    assign covered = covered_reg;

endmodule

// File: hw/rtl/fcf_div.sv
// restoring divider, one quotient bit per cycle
module fcf_div
    import fcf_pkg::*;
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 44,
    parameter int Q_W   = FIT_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [Q_W-1:0]   quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_sr_reg, num_sr_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, num_sr_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        num_sr_next = num_sr_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        if (go)
        begin
            cnt_next    = CNT_W'(NUM_W);
            num_sr_next = num;
            den_next    = den;
            rem_next    = '0;
            quo_next    = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next    = cnt_reg - CNT_W'(1);
            num_sr_next = {num_sr_reg[NUM_W-2:0], 1'b0};
            rem_next    = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next    = {quo_reg[Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_sr_reg <= num_sr_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

    assign busy = go || (cnt_reg != '0);
    assign quo  = quo_reg;

endmodule

// File: hw/rtl/fcf_chk.sv
// port checker for the transmitter coverage fitness block and its bind
module fcf_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [8:0]  pos_x,
    input logic [8:0]  pos_y,
    input logic        selected,
    input logic        invalid_mark,
    input logic        last_item,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] covered_cells,
    input logic [9:0]  used_count,
    input logic [29:0] fitness_q16,
    input logic        none_used,
    input logic        was_invalid
);

    // a selected word keeps the input closed for the next cycle
    a_sel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && selected |=> !in_ready)
        else $error("input ready right after a selected word");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && none_used |-> (fitness_q16 == 30'd0) && (used_count == 10'd0))
        else $error("no transmitter used but fitness or count nonzero");

    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_invalid |-> fitness_q16 == 30'd0)
        else $error("invalid solution with nonzero fitness");

    // last word closes the input until the result has been formed
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_item |=> !in_ready)
        else $error("input ready right after a last word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fitness_q16)
            && $stable(covered_cells))
        else $error("stalled result word changed");

endmodule

bind transmitter_coverage_fitness fcf_chk u_fcf_chk (.*);

// File: tb/transmitter_coverage_fitness_tb.sv
// self-checking testbench for the transmitter coverage fitness block
`timescale 1ns / 1ps

module transmitter_coverage_fitness_tb;
    import fcf_pkg::*;

    localparam int GRID        = GRID_SIDE_DEF;
    localparam int RADIUS      = COVER_RADIUS_DEF;
    localparam int MAX_TX      = MAX_TX_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_WAIT  = 600;
    localparam int PHASE_WORDS = 125;
    localparam int TILE_EXTRA  = 4;
    localparam int N_DIRECTED  = 17;

    typedef struct packed {
        logic [COVERED_W-1:0]  cells;
        logic [USED_OUT_W-1:0] used;
        logic [FIT_W-1:0]      fit;
        logic                  none;
        logic                  inval;
    } score_t;

    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic             sel;
        logic             inv;
        logic             last;
        logic             typed;
        score_t           want;
    } word_t;

    // x, y, selected, invalid, last, typed, typed score
    localparam word_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{9'd0,   9'd0,   1'b0, 1'b0, 1'b1, 1'b1, '{17'd0,   10'd0, 30'd0, 1'b1, 1'b0}},
        '{9'd0,   9'd0,   1'b1, 1'b1, 1'b1, 1'b1, '{17'd441, 10'd1, 30'd0, 1'b0, 1'b1}},
        '{9'd511, 9'd511, 1'b1, 1'b0, 1'b1, 1'b1, '{17'd0,   10'd1, 30'd0, 1'b0, 1'b0}},
        '{9'd286, 9'd286, 1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{9'd143, 9'd143, 1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{9'd143, 9'd143, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{9'd143, 9'd143, 1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{9'd306, 9'd0,   1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{9'd0,   9'd306, 1'b0, 1'b1, 1'b0, 1'b0, '0},
        '{9'd100, 9'd100, 1'b0, 1'b0, 1'b1, 1'b1, '{17'd21,  10'd1, 30'd0, 1'b0, 1'b1}},
        '{9'd286, 9'd0,   1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{9'd0,   9'd286, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{9'd255, 9'd256, 1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{9'd170, 9'd85,  1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{9'd85,  9'd170, 1'b1, 1'b1, 1'b0, 1'b0, '0},
        '{9'd20,  9'd20,  1'b0, 1'b0, 1'b1, 1'b0, '0},
        '{9'd0,   9'd0,   1'b0, 1'b1, 1'b1, 1'b1, '{17'd0,   10'd0, 30'd0, 1'b1, 1'b1}}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [POS_W-1:0]      pos_x = '0;
    logic [POS_W-1:0]      pos_y = '0;
    logic                  selected = 1'b0;
    logic                  invalid_mark = 1'b0;
    logic                  last_item = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [COVERED_W-1:0]  covered_cells;
    logic [USED_OUT_W-1:0] used_count;
    logic [FIT_W-1:0]      fitness_q16;
    logic                  none_used;
    logic                  was_invalid;

    transmitter_coverage_fitness dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .selected      (selected),
        .invalid_mark  (invalid_mark),
        .last_item     (last_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .covered_cells (covered_cells),
        .used_count    (used_count),
        .fitness_q16   (fitness_q16),
        .none_used     (none_used),
        .was_invalid   (was_invalid)
    );

    always #5 clk = ~clk;

    // coverage map and solution totals
    bit [GRID-1:0] cover_map [GRID];
    int unsigned   cover_count;
    int unsigned   tx_used;
    bit            solution_invalid;

    score_t expected_scores [$];

    int tx_idle_pct = 15;
    int rx_idle_pct = 66;
    bit hold_req = 1'b0;
    bit hold_ack = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;
    int errors = 0;
    int words_sent = 0;
    int solutions_sent = 0;
    int scores_seen = 0;
    int none_seen = 0;
    int invalid_seen = 0;
    int full_seen = 0;

    function automatic logic [FIT_W-1:0] fitness_of(int unsigned cov, int unsigned used);
        bit [127:0] num;
        bit [127:0] den;
        begin
            num = cov;
            num = num * 100;
            num = (num * num) << FRAC_W;
            den = GRID * GRID;
            den = den * den * used;
            return FIT_W'(num / den);
        end
    endfunction

    task automatic clear_solution();
        foreach (cover_map[i])
            cover_map[i] = '0;
        cover_count = 0;
        tx_used = 0;
        solution_invalid = 1'b0;
    endtask

    task automatic paint_square(int cx, int cy);
        int x0;
        int x1;
        int y0;
        int y1;
        begin
            x0 = (cx - RADIUS < 0) ? 0 : cx - RADIUS;
            y0 = (cy - RADIUS < 0) ? 0 : cy - RADIUS;
            x1 = (cx + RADIUS > GRID - 1) ? GRID - 1 : cx + RADIUS;
            y1 = (cy + RADIUS > GRID - 1) ? GRID - 1 : cy + RADIUS;
            for (int x = x0; x <= x1; x++)
                for (int y = y0; y <= y1; y++)
                    if (!cover_map[x][y])
                    begin
                        cover_map[x][y] = 1'b1;
                        cover_count++;
                    end
        end
    endtask

    task automatic score_transmitter(input word_t w, output bit has_score, output score_t s);
        begin
            has_score = 1'b0;
            s = '0;
            if (w.inv)
                solution_invalid = 1'b1;
            if (w.sel)
            begin
                if (tx_used < MAX_TX)
                    tx_used++;
                paint_square(w.px, w.py);
            end
            if (w.last)
            begin
                has_score = 1'b1;
                s.cells = COVERED_W'(cover_count);
                s.used  = USED_OUT_W'(tx_used);
                s.none  = (tx_used == 0);
                s.inval = solution_invalid;
                s.fit   = (s.none || solution_invalid) ? '0 : fitness_of(cover_count, tx_used);
                clear_solution();
            end
        end
    endtask

    // drive one word and wait for it to be taken
    task automatic send_word(input word_t w);
        bit     has_score;
        score_t s;
        begin
            while ($urandom_range(99) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid     <= 1'b1;
            pos_x        <= w.px;
            pos_y        <= w.py;
            selected     <= w.sel;
            invalid_mark <= w.inv;
            last_item    <= w.last;
            do
                @(posedge clk);
            while (!in_ready);
            words_sent++;
            score_transmitter(w, has_score, s);
            if (has_score)
            begin
                expected_scores.push_back(w.typed ? w.want : s);
                solutions_sent++;
            end
        end
    endtask

    task automatic drain_scores();
        while (expected_scores.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_solutions(int n_words);
        int    count;
        int    len;
        bit    quiet;
        word_t w;
        begin
            count = 0;
            while (count < n_words)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
                quiet = ($urandom_range(11) == 0);
                for (int i = 0; i < len; i++)
                begin
                    w = '0;
                    if ($urandom_range(99) < 85)
                    begin
                        w.px = POS_W'($urandom_range(GRID - 1));
                        w.py = POS_W'($urandom_range(GRID - 1));
                    end
                    else
                    begin
                        w.px = POS_W'($urandom);
                        w.py = POS_W'($urandom);
                    end
                    w.sel  = !quiet && ($urandom_range(99) < 70);
                    w.inv  = ($urandom_range(99) < 4);
                    w.last = (i == len - 1);
                    send_word(w);
                end
                count += len;
            end
        end
    endtask

    // full-grid tiling followed by a few overlapping transmitters
    task automatic full_grid_solution();
        word_t w;
        begin
            w = '0;
            w.sel = 1'b1;
            for (int i = 0; i < 7; i++)
                for (int j = 0; j < 7; j++)
                begin
                    w.px = POS_W'(RADIUS + i * (2 * RADIUS + 1));
                    w.py = POS_W'(RADIUS + j * (2 * RADIUS + 1));
                    send_word(w);
                end
            for (int k = 0; k < TILE_EXTRA; k++)
            begin
                w.px   = POS_W'($urandom);
                w.py   = POS_W'($urandom);
                w.last = (k == TILE_EXTRA - 1);
                send_word(w);
            end
        end
    endtask

    // receive side: result checks, random stalls and the long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            scores_seen++;
            none_seen += none_used;
            invalid_seen += was_invalid;
            full_seen += (covered_cells == COVERED_W'(GRID * GRID));
            if (expected_scores.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: cells %0d used %0d fit %0d none %0b inv %0b",
                             covered_cells, used_count, fitness_q16, none_used, was_invalid);
            end
            else
            begin
                score_t want;
                want = expected_scores.pop_front();
                if (covered_cells !== want.cells || used_count !== want.used ||
                    fitness_q16 !== want.fit || none_used !== want.none ||
                    was_invalid !== want.inval)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: cells %0d/%0d used %0d/%0d fit %0d/%0d none %0b/%0b inv %0b/%0b",
                                 want.cells, covered_cells, want.used, used_count,
                                 want.fit, fitness_q16, want.none, none_used,
                                 want.inval, was_invalid);
                end
            end
        end
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        clear_solution();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
            send_word(DIRECTED_ROWS[r]);
        in_valid <= 1'b0;
        drain_scores();

        full_grid_solution();
        in_valid <= 1'b0;
        drain_scores();

        random_solutions(PHASE_WORDS);
        in_valid <= 1'b0;
        drain_scores();

        tx_idle_pct = 66;
        rx_idle_pct = 15;
        random_solutions(PHASE_WORDS);
        in_valid <= 1'b0;
        drain_scores();

        // no idling, with the receiver blocked for a while at the start
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = ~hold_req;
        random_solutions(PHASE_WORDS);
        in_valid <= 1'b0;
        drain_scores();

        repeat (DRAIN_WAIT) @(posedge clk);
        errors += expected_scores.size();

        $display("%0d words in %0d solutions, %0d scores checked, %0d mismatches",
                 words_sent, solutions_sent, scores_seen, errors);
        $display("none-used %0d, invalid %0d, full-grid %0d",
                 none_seen, invalid_seen, full_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
